[rtl/cloud_in_cell_mass_deposit_unit_macros.svh]
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit unit assertion macros
// Clocked assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef CLOUD_IN_CELL_MASS_DEPOSIT_UNIT_MACROS_SVH
`define CLOUD_IN_CELL_MASS_DEPOSIT_UNIT_MACROS_SVH

// same-cycle implication
`define CICMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CICMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cicmd_pkg.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit package
// Grid geometry, widths, register indexes and the grid port struct.
// ----------------------------------------------------------------------------
package cicmd_pkg;

  localparam int unsigned GRID_SIDE = 32;
  localparam int unsigned AXIS_W    = $clog2(GRID_SIDE);
  localparam int unsigned ADDR_W    = 3 * AXIS_W;
  localparam int unsigned DENS_W    = 48;
  localparam int unsigned ENTRY_W   = DENS_W + 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [1:0] CFG_LTG   = 2'd0;
  localparam logic [1:0] CFG_SHIFT = 2'd1;
  localparam logic [1:0] CFG_IPV   = 2'd2;

  localparam logic [DENS_W-1:0] DENS_MAX = '1;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } grid_req_t;

endpackage

[rtl/cicmd_mul.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell shared multiplier
// One 32 x 32 unsigned multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module cicmd_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;
endmodule

[rtl/cicmd_grid.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell density grid
// Single-ported cell store with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module cicmd_grid (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cicmd_pkg::grid_req_t         req_i,
  output logic [cicmd_pkg::ENTRY_W-1:0] rdata_o,
  output logic                         clearing_o
);
  import cicmd_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ADDR_W:0]    clr_q;
  logic [ADDR_W:0]    clr_d;

  assign clearing_o = ~clr_q[ADDR_W];
  assign clr_d      = clearing_o ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_o) begin
      mem[clr_q[ADDR_W-1:0]] <= '0;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/cloud_in_cell_mass_deposit_unit.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell mass deposit unit
// Deposit: busy through the axis splits, the mass density, the x-y weight pairs
// and the per-cell steps on the shared multiplier; no result.
// Read: the result strobes in the first cycle with busy low.
// After reset the grid is swept to zero; busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
module cloud_in_cell_mass_deposit_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cmd_i,
  input  logic [31:0]                       pos_x_i,
  input  logic [31:0]                       pos_y_i,
  input  logic [31:0]                       pos_z_i,
  input  logic [31:0]                       particle_mass_i,
  input  logic [cicmd_pkg::AXIS_W-1:0]      read_x_i,
  input  logic [cicmd_pkg::AXIS_W-1:0]      read_y_i,
  input  logic [cicmd_pkg::AXIS_W-1:0]      read_z_i,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [cicmd_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                              valid_o,
  output logic [cicmd_pkg::DENS_W-1:0]      cell_density_o,
  output logic                              saturated_o
);
  import cicmd_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AX, S_AXW, S_MM, S_MMW, S_WXY, S_WXYW,
    S_WT, S_WTW, S_AL, S_ALW, S_AH, S_AHW, S_RD, S_RDW
  } state_e;

  state_e             state_q;
  logic [31:0]        ltg_q;
  logic [15:0]        shift_q;
  logic [31:0]        ipv_q;
  logic [31:0]        pos_q [3];
  logic [31:0]        mass_q;
  logic [1:0]         ax_q;
  logic [AXIS_W-1:0]  c_q [3];
  logic [15:0]        h_q [3];
  logic [DENS_W-1:0]  m_q;
  logic [16:0]        wxy_q;
  logic [16:0]        wt_q;
  logic [40:0]        plo_q;
  logic [2:0]         idx_q;
  logic [ADDR_W-1:0]  raddr_q;
  logic               valid_q;
  logic [DENS_W-1:0]  dens_q;
  logic               sat_q;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        p;
  grid_req_t          req;
  logic [ENTRY_W-1:0] rdata;
  logic               clearing;

  logic [63:0]        g_s;
  logic [63:0]        u;
  logic               ge;
  logic [16:0]        wx;
  logic [16:0]        wy;
  logic [16:0]        wz;
  logic [AXIS_W-1:0]  cx;
  logic [AXIS_W-1:0]  cy;
  logic [AXIS_W-1:0]  cz;
  logic [65:0]        total;
  logic [49:0]        amount;
  logic [50:0]        sum;
  logic               ovf;

  cicmd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  cicmd_grid u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  function automatic logic [16:0] weight(input logic sel, input logic [15:0] h);
    weight = sel ? {1'b0, h} : 17'(18'h10000 - 18'(h));
  endfunction

  always_comb begin
    g_s    = {32'd0, shift_q, 16'd0};
    ge     = p >= g_s;
    u      = p - g_s;
    wx     = weight(idx_q[2], h_q[0]);
    wy     = weight(idx_q[1], h_q[1]);
    wz     = weight(idx_q[0], h_q[2]);
    cx     = c_q[0] + AXIS_W'(idx_q[2]);
    cy     = c_q[1] + AXIS_W'(idx_q[1]);
    cz     = c_q[2] + AXIS_W'(idx_q[0]);
    total  = {1'b0, p[40:0], 24'd0} + 66'(plo_q);
    amount = total[65:16];
    sum    = 51'(rdata[DENS_W-1:0]) + 51'(amount);
    ovf    = sum > 51'(DENS_MAX);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_AX: begin
        mul_a = pos_q[ax_q];
        mul_b = ltg_q;
      end
      S_MM: begin
        mul_a = mass_q;
        mul_b = ipv_q;
      end
      S_WXY: begin
        mul_a = 32'(wx);
        mul_b = 32'(wy);
      end
      S_WT: begin
        mul_a = 32'(wxy_q);
        mul_b = 32'(wz);
      end
      S_AL: begin
        mul_a = 32'(m_q[23:0]);
        mul_b = 32'(wt_q);
      end
      S_AH: begin
        mul_a = 32'(m_q[47:24]);
        mul_b = 32'(wt_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    req.we    = state_q == S_AHW;
    req.re    = (state_q == S_WT) || (state_q == S_RD);
    req.addr  = (state_q == S_RD) ? raddr_q : {cx, cy, cz};
    req.wdata = ovf ? {1'b1, DENS_MAX} : {rdata[DENS_W], sum[DENS_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ltg_q   <= 32'd65536;
      shift_q <= '0;
      ipv_q   <= 32'd20697866;
      ax_q    <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LTG:   ltg_q   <= cfg_data_i;
          CFG_SHIFT: shift_q <= cfg_data_i[15:0];
          CFG_IPV:   ipv_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          if (!clearing) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            pos_q[0] <= pos_x_i;
            pos_q[1] <= pos_y_i;
            pos_q[2] <= pos_z_i;
            mass_q   <= particle_mass_i;
            raddr_q  <= {read_x_i, read_y_i, read_z_i};
            ax_q     <= '0;
            idx_q    <= '0;
            state_q  <= cmd_i ? S_RD : S_AX;
          end
        end
        S_AX:  state_q <= S_AXW;
        S_AXW: begin
          c_q[ax_q] <= ge ? u[32 +: AXIS_W] : AXIS_W'(GRID_SIDE - 1);
          h_q[ax_q] <= u[31:16];
          ax_q      <= ax_q + 1'b1;
          state_q   <= (ax_q == 2'd2) ? S_MM : S_AX;
        end
        S_MM:  state_q <= S_MMW;
        S_MMW: begin
          m_q     <= p[63:16];
          state_q <= S_WXY;
        end
        S_WXY:  state_q <= S_WXYW;
        S_WXYW: begin
          wxy_q   <= p[32:16];
          state_q <= S_WT;
        end
        S_WT:  state_q <= S_WTW;
        S_WTW: begin
          wt_q    <= p[32:16];
          state_q <= S_AL;
        end
        S_AL:  state_q <= S_ALW;
        S_ALW: begin
          plo_q   <= p[40:0];
          state_q <= S_AH;
        end
        S_AH:  state_q <= S_AHW;
        S_AHW: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == 3'd7) begin
            state_q <= S_IDLE;
          end else if (idx_q[0]) begin
            state_q <= S_WXY;
          end else begin
            state_q <= S_WT;
          end
        end
        S_RD:  state_q <= S_RDW;
        S_RDW: begin
          dens_q  <= rdata[DENS_W-1:0];
          sat_q   <= rdata[DENS_W];
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = state_q != S_IDLE;
  assign valid_o        = valid_q;
  assign cell_density_o = dens_q;
  assign saturated_o    = sat_q;
endmodule

[rtl/cicmd_checker.sv]
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit port checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "cloud_in_cell_mass_deposit_unit_macros.svh"

module cicmd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);
  `CICMD_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "item taken but not busy")
  `CICMD_ASSERT_NOW(a_valid_idle, valid_o, !busy_o, "result while busy")
  `CICMD_ASSERT_NEXT(a_valid_single, valid_o, !valid_o, "result strobe held")
  `CICMD_ASSERT_NOW(a_valid_after_work, valid_o, $past(busy_o), "result without work")
endmodule

bind cloud_in_cell_mass_deposit_unit cicmd_checker u_cicmd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o)
);
